[rtl/pidpa_pkg.sv]
// ----------------------------------------------------------------------------
// pidpa_pkg
// Shared types and constants for the positional PID axis: register map,
// field widths, reset values of the configuration registers.
// ----------------------------------------------------------------------------
package pidpa_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  // register field widths
  localparam int unsigned GAIN_W  = 8;
  localparam int unsigned LIMIT_W = 11;
  localparam int unsigned DBAND_W = 4;

  // integral state and drive widths
  localparam int unsigned SUM_W   = 12;
  localparam int unsigned DRIVE_W = 12;

  // product width of a gain and the integral
  localparam int unsigned IPROD_W = SUM_W + GAIN_W + 1;

  // reset values
  localparam logic [GAIN_W-1:0]  GAIN_P_RST    = 8'd14;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST    = 8'd0;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST    = 8'd35;
  localparam logic [LIMIT_W-1:0] INT_LIMIT_RST = 11'd100;
  localparam logic [LIMIT_W-1:0] OUT_LIMIT_RST = 11'd350;
  localparam logic [DBAND_W-1:0] DBAND_RST     = 4'd1;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P    = 3'd0,
    CFG_GAIN_I    = 3'd1,
    CFG_GAIN_D    = 3'd2,
    CFG_INT_LIMIT = 3'd3,
    CFG_OUT_LIMIT = 3'd4,
    CFG_DEAD_BAND = 3'd5
  } cfg_idx_e;

  // current register contents
  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [LIMIT_W-1:0] integral_limit;
    logic [LIMIT_W-1:0] output_limit;
    logic [DBAND_W-1:0] dead_band;
  } cfg_t;

endpackage

[rtl/pidpa_cfg_regs.sv]
// ----------------------------------------------------------------------------
// pidpa_cfg_regs
// Configuration register file: gains, limits and dead band, one write per
// cycle, unknown indexes ignored.
// ----------------------------------------------------------------------------
module pidpa_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pidpa_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pidpa_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output pidpa_pkg::cfg_t                      cfg_o
);

  pidpa_pkg::cfg_t cfg_q;

  // writes are always taken
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // register write decode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p         <= pidpa_pkg::GAIN_P_RST;
      cfg_q.gain_i         <= pidpa_pkg::GAIN_I_RST;
      cfg_q.gain_d         <= pidpa_pkg::GAIN_D_RST;
      cfg_q.integral_limit <= pidpa_pkg::INT_LIMIT_RST;
      cfg_q.output_limit   <= pidpa_pkg::OUT_LIMIT_RST;
      cfg_q.dead_band      <= pidpa_pkg::DBAND_RST;
    end else if (cfg_valid_i) begin
      unique case (pidpa_pkg::cfg_idx_e'(cfg_index_i))
        pidpa_pkg::CFG_GAIN_P:    cfg_q.gain_p <= cfg_data_i[pidpa_pkg::GAIN_W-1:0];
        pidpa_pkg::CFG_GAIN_I:    cfg_q.gain_i <= cfg_data_i[pidpa_pkg::GAIN_W-1:0];
        pidpa_pkg::CFG_GAIN_D:    cfg_q.gain_d <= cfg_data_i[pidpa_pkg::GAIN_W-1:0];
        pidpa_pkg::CFG_INT_LIMIT: begin
          cfg_q.integral_limit <= cfg_data_i[pidpa_pkg::LIMIT_W-1:0];
        end
        pidpa_pkg::CFG_OUT_LIMIT: begin
          cfg_q.output_limit <= cfg_data_i[pidpa_pkg::LIMIT_W-1:0];
        end
        pidpa_pkg::CFG_DEAD_BAND: cfg_q.dead_band <= cfg_data_i[pidpa_pkg::DBAND_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/pidpa_error_unit.sv]
// ----------------------------------------------------------------------------
// pidpa_error_unit
// Error with dead band, clamped integral and measurement difference; holds
// the integral and the previous position, updated as each item moves on.
// ----------------------------------------------------------------------------
module pidpa_error_unit #(
  parameter int unsigned POS_BITS = 10
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   advance_i,
  input  logic [pidpa_pkg::DBAND_W-1:0]          dead_band_i,
  input  logic [pidpa_pkg::LIMIT_W-1:0]          integral_limit_i,
  input  logic [POS_BITS-1:0]                    target_pos_i,
  input  logic [POS_BITS-1:0]                    measured_pos_i,
  output logic signed [POS_BITS:0]               err_o,
  output logic signed [pidpa_pkg::SUM_W-1:0]     sum_o,
  output logic signed [POS_BITS:0]               diff_o
);

  localparam int unsigned ERR_W = POS_BITS + 1;
  localparam int unsigned ACC_W =
    ((ERR_W > pidpa_pkg::SUM_W) ? ERR_W : pidpa_pkg::SUM_W) + 1;

  logic signed [pidpa_pkg::SUM_W-1:0] error_sum_q;
  logic [POS_BITS-1:0]                prev_pos_q;

  logic signed [ERR_W-1:0] err_raw;
  logic [ERR_W-1:0]        err_mag;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] ilim;
  logic signed [ACC_W-1:0] acc_clamped;

  // error and dead band
  always_comb begin
    err_raw = $signed({1'b0, target_pos_i}) - $signed({1'b0, measured_pos_i});
    err_mag = err_raw[ERR_W-1] ? ERR_W'(-err_raw) : ERR_W'(err_raw);
    err_o   = (err_mag <= ERR_W'(dead_band_i)) ? '0 : err_raw;
  end

  // integral with symmetric clamp
  always_comb begin
    acc  = ACC_W'(error_sum_q) + ACC_W'(err_o);
    ilim = $signed(ACC_W'({1'b0, integral_limit_i}));
    if (acc > ilim) begin
      acc_clamped = ilim;
    end else if (acc < -ilim) begin
      acc_clamped = -ilim;
    end else begin
      acc_clamped = acc;
    end
    sum_o = pidpa_pkg::SUM_W'(acc_clamped);
  end

  // derivative on the measurement
  assign diff_o = $signed({1'b0, measured_pos_i}) - $signed({1'b0, prev_pos_q});

  // loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_sum_q <= '0;
      prev_pos_q  <= '0;
    end else if (advance_i) begin
      error_sum_q <= sum_o;
      prev_pos_q  <= measured_pos_i;
    end
  end

endmodule

[rtl/pidpa_drive_clamp.sv]
// ----------------------------------------------------------------------------
// pidpa_drive_clamp
// Sums the three gain products and limits the drive to the output limit,
// flagging any item whose raw drive lies beyond it.
// ----------------------------------------------------------------------------
module pidpa_drive_clamp #(
  parameter int unsigned POS_BITS = 10
) (
  input  logic signed [POS_BITS+9:0]               p_prod_i,
  input  logic signed [pidpa_pkg::IPROD_W-1:0]     i_prod_i,
  input  logic signed [POS_BITS+9:0]               d_prod_i,
  input  logic [pidpa_pkg::LIMIT_W-1:0]            output_limit_i,
  output logic signed [pidpa_pkg::DRIVE_W-1:0]     drive_o,
  output logic                                     clamped_o
);

  localparam int unsigned PROD_W = POS_BITS + 10;
  localparam int unsigned RAW_W  =
    ((PROD_W > pidpa_pkg::IPROD_W) ? PROD_W : pidpa_pkg::IPROD_W) + 2;

  logic signed [RAW_W-1:0] raw;
  logic signed [RAW_W-1:0] lim;
  logic signed [RAW_W-1:0] limited;

  // sum and symmetric clamp
  always_comb begin
    raw = RAW_W'(p_prod_i) + RAW_W'(i_prod_i) + RAW_W'(d_prod_i);
    lim = $signed(RAW_W'({1'b0, output_limit_i}));
    if (raw > lim) begin
      limited   = lim;
      clamped_o = 1'b1;
    end else if (raw < -lim) begin
      limited   = -lim;
      clamped_o = 1'b1;
    end else begin
      limited   = raw;
      clamped_o = 1'b0;
    end
    drive_o = pidpa_pkg::DRIVE_W'(limited);
  end

endmodule

[rtl/pid_position_axis.sv]
// ----------------------------------------------------------------------------
// pid_position_axis
// One servo axis of a positional PID: dead-banded error, clamped integral,
// derivative on the measurement, clamped drive with a limit flag.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  in       | in_valid_i, in_ready_o, target_pos_i,     | sink
//           | measured_pos_i                            |
//  out      | out_valid_o, out_ready_i, drive_o,        | source
//           | clamped_o                                 |
//  cfg      | cfg_valid_i, cfg_ready_o, cfg_index_i,    | sink
//           | cfg_data_i                                |
//
//  One item per cycle while out_ready_i does not stall the output; an item passes
//  the input register, error/integral stage, product stage and drive register.
//  The integral and previous position update as an item leaves the input
//  register, so consecutive items see each other's state with no gap.
//  Each stage holds its item on a stall and empty stages fill up, so input
//  ready drops only once all four registers are occupied.
//  Reset restores the register defaults and clears integral and position.
// ----------------------------------------------------------------------------
module pid_position_axis #(
  parameter int unsigned POS_BITS = 10
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [POS_BITS-1:0]                    target_pos_i,
  input  logic [POS_BITS-1:0]                    measured_pos_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [pidpa_pkg::DRIVE_W-1:0]   drive_o,
  output logic                                   clamped_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [pidpa_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [pidpa_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int unsigned ERR_W  = POS_BITS + 1;
  localparam int unsigned PROD_W = POS_BITS + 10;

  pidpa_pkg::cfg_t cfg;

  // stage valids and ready chain
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  // stage payloads
  logic [POS_BITS-1:0]                   tgt1_q, meas1_q;
  logic signed [ERR_W-1:0]               err2_q, diff2_q;
  logic signed [pidpa_pkg::SUM_W-1:0]    sum2_q;
  logic signed [PROD_W-1:0]              pp3_q, dp3_q;
  logic signed [pidpa_pkg::IPROD_W-1:0]  ip3_q;
  logic signed [pidpa_pkg::DRIVE_W-1:0]  drive4_q;
  logic                                  clamped4_q;

  // combinational results
  logic signed [ERR_W-1:0]               err_d, diff_d;
  logic signed [pidpa_pkg::SUM_W-1:0]    sum_d;
  logic signed [PROD_W-1:0]              pp_d, dp_d;
  logic signed [pidpa_pkg::IPROD_W-1:0]  ip_d;
  logic signed [pidpa_pkg::DRIVE_W-1:0]  drive_d;
  logic                                  clamped_d;
  logic                                  advance;

  // configuration registers
  pidpa_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // a stage may load when it is empty or its item moves on
  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;
  assign advance    = v1_q && rdy2;

  // error, integral and difference
  pidpa_error_unit #(
    .POS_BITS (POS_BITS)
  ) u_err (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .advance_i        (advance),
    .dead_band_i      (cfg.dead_band),
    .integral_limit_i (cfg.integral_limit),
    .target_pos_i     (tgt1_q),
    .measured_pos_i   (meas1_q),
    .err_o            (err_d),
    .sum_o            (sum_d),
    .diff_o           (diff_d)
  );

  // gain products
  assign pp_d = $signed({1'b0, cfg.gain_p}) * err2_q;
  assign ip_d = $signed({1'b0, cfg.gain_i}) * sum2_q;
  assign dp_d = $signed({1'b0, cfg.gain_d}) * diff2_q;

  // drive sum and limit
  pidpa_drive_clamp #(
    .POS_BITS (POS_BITS)
  ) u_drv (
    .p_prod_i       (pp3_q),
    .i_prod_i       (ip3_q),
    .d_prod_i       (dp3_q),
    .output_limit_i (cfg.output_limit),
    .drive_o        (drive_d),
    .clamped_o      (clamped_d)
  );

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      tgt1_q  <= target_pos_i;
      meas1_q <= measured_pos_i;
    end
    if (rdy2) begin
      err2_q  <= err_d;
      sum2_q  <= sum_d;
      diff2_q <= diff_d;
    end
    if (rdy3) begin
      pp3_q <= pp_d;
      ip3_q <= ip_d;
      dp3_q <= dp_d;
    end
    if (rdy4) begin
      drive4_q   <= drive_d;
      clamped4_q <= clamped_d;
    end
  end

  assign out_valid_o = v4_q;
  assign drive_o     = drive4_q;
  assign clamped_o   = clamped4_q;

  // input back-pressure only when every stage holds an item
  a_full_when_blocked : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && v4_q)
  ) else $error("input blocked with an empty stage");

  // a stalled product stage keeps its item
  a_prod_hold : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !rdy4) |=> (v3_q && $stable(pp3_q) && $stable(ip3_q) && $stable(dp3_q))
  ) else $error("product stage lost its item under stall");

  // the error stage fills only from the input register
  a_err_source : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(v2_q) |-> $past(v1_q)
  ) else $error("error stage filled without an input item");

endmodule

[tb/sv/tb_pid_position_axis.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_position_axis
// Self-checking bench for one positional PID servo axis. Samples are queued
// by a stimulus process and handed over by a clocked driver with random gaps.
// A clocked monitor takes results with random stalls. Each accepted sample
// runs through a local model of the axis: dead band, clamped integral,
// derivative on the measurement, clamped drive. The model's result is held
// in order and compared field by field. Registers are rewritten only once
// the axis has drained.
// ----------------------------------------------------------------------------
module tb_pid_position_axis;

  localparam int unsigned POS_BITS = 10;
  localparam int unsigned DATA_W   = pidpa_pkg::CFG_DATA_W;
  localparam int          POS_MAX  = (1 << POS_BITS) - 1;
  localparam int          DATA_MAX = (1 << pidpa_pkg::CFG_DATA_W) - 1;

  // indexes outside the register map, writes there must be ignored
  localparam logic [pidpa_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [pidpa_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [POS_BITS-1:0] target;
    logic [POS_BITS-1:0] meas;
  } sample_t;

  typedef struct {
    logic signed [pidpa_pkg::DRIVE_W-1:0] drive;
    logic                                 clamped;
  } drive_res_t;

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 in_valid_i;
  logic                                 in_ready_o;
  logic [POS_BITS-1:0]                  target_pos_i;
  logic [POS_BITS-1:0]                  measured_pos_i;
  logic                                 out_valid_o;
  logic                                 out_ready_i;
  logic signed [pidpa_pkg::DRIVE_W-1:0] drive_o;
  logic                                 clamped_o;
  logic                                 cfg_valid_i;
  logic                                 cfg_ready_o;
  logic [pidpa_pkg::CFG_IDX_W-1:0]      cfg_index_i;
  logic [pidpa_pkg::CFG_DATA_W-1:0]     cfg_data_i;

  // samples waiting for the driver, drives waiting for the axis
  sample_t    sample_q[$];
  drive_res_t drive_exp_q[$];

  // local copy of the axis registers and state
  pidpa_pkg::cfg_t                    servo_regs;
  logic signed [pidpa_pkg::SUM_W-1:0] integ_acc;
  logic [POS_BITS-1:0]                last_meas;

  bit in_taken;
  bit out_taken;
  bit quiet;
  int in_gap;
  int out_stall;
  int err_cnt;

  pid_position_axis #(
    .POS_BITS(POS_BITS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .target_pos_i  (target_pos_i),
    .measured_pos_i(measured_pos_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .drive_o       (drive_o),
    .clamped_o     (clamped_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // one control step of the axis, updates integral and stored position
  function automatic drive_res_t servo_drive(input logic [POS_BITS-1:0] tgt,
                                             input logic [POS_BITS-1:0] pos);
    longint     err;
    longint     mag;
    longint     sum;
    longint     raw;
    longint     drv;
    drive_res_t res;
    err = longint'(tgt) - longint'(pos);
    mag = (err < 0) ? -err : err;
    if (mag <= longint'(servo_regs.dead_band)) err = 0;
    sum = clamp_sym(longint'(integ_acc) + err, longint'(servo_regs.integral_limit));
    integ_acc = sum[pidpa_pkg::SUM_W-1:0];
    raw = longint'(servo_regs.gain_p) * err
        + longint'(servo_regs.gain_i) * sum
        + longint'(servo_regs.gain_d) * (longint'(pos) - longint'(last_meas));
    last_meas = pos;
    drv = clamp_sym(raw, longint'(servo_regs.output_limit));
    res.drive   = drv[pidpa_pkg::DRIVE_W-1:0];
    res.clamped = (drv != raw);
    return res;
  endfunction

  // register write as seen by the axis, upper data bits dropped
  function automatic void apply_reg(input logic [pidpa_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [pidpa_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      pidpa_pkg::CFG_GAIN_P:    servo_regs.gain_p         = data[pidpa_pkg::GAIN_W-1:0];
      pidpa_pkg::CFG_GAIN_I:    servo_regs.gain_i         = data[pidpa_pkg::GAIN_W-1:0];
      pidpa_pkg::CFG_GAIN_D:    servo_regs.gain_d         = data[pidpa_pkg::GAIN_W-1:0];
      pidpa_pkg::CFG_INT_LIMIT: servo_regs.integral_limit = data[pidpa_pkg::LIMIT_W-1:0];
      pidpa_pkg::CFG_OUT_LIMIT: servo_regs.output_limit   = data[pidpa_pkg::LIMIT_W-1:0];
      pidpa_pkg::CFG_DEAD_BAND: servo_regs.dead_band      = data[pidpa_pkg::DBAND_W-1:0];
      default: ;
    endcase
  endfunction

  // sample driver, gap drawn per item
  always @(negedge clk_i) begin
    sample_t nxt;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (in_valid_i) in_gap = quiet ? 0 : $urandom_range(0, 11);
      if (in_gap > 0 || sample_q.size() == 0) begin
        if (in_gap > 0) in_gap--;
        in_valid_i <= 1'b0;
      end else begin
        nxt = sample_q.pop_front();
        target_pos_i   <= nxt.target;
        measured_pos_i <= nxt.meas;
        in_valid_i     <= 1'b1;
      end
    end
  end

  // result back-pressure, stall drawn per item
  always @(negedge clk_i) begin
    if (out_taken) out_stall = quiet ? 0 : $urandom_range(0, 11);
    if (out_stall > 0) begin
      out_stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // monitor: register writes, accepted samples, result checks
  always @(posedge clk_i) begin
    drive_res_t want;
    if (!rst_ni) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= in_valid_i && in_ready_o;
      out_taken <= out_valid_o && out_ready_i;
      if (cfg_valid_i && cfg_ready_o) apply_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o)
        drive_exp_q.push_back(servo_drive(target_pos_i, measured_pos_i));
      if (out_valid_o && out_ready_i) begin
        if (drive_exp_q.size() == 0) begin
          err_cnt++;
          $display("%0t unexpected item: drive %0d clamped %0b", $time, drive_o, clamped_o);
        end else begin
          want = drive_exp_q.pop_front();
          if (drive_o !== want.drive) begin
            err_cnt++;
            $display("%0t drive mismatch: expected %0d, got %0d", $time, want.drive, drive_o);
          end
          if (clamped_o !== want.clamped) begin
            err_cnt++;
            $display("%0t clamped mismatch: expected %0b, got %0b", $time, want.clamped,
                     clamped_o);
          end
        end
      end
    end
  end

  task automatic push_sample(input int tgt, input int pos);
    sample_t s;
    s.target = tgt[POS_BITS-1:0];
    s.meas   = pos[POS_BITS-1:0];
    sample_q.push_back(s);
  endtask

  task automatic write_reg(input logic [pidpa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pidpa_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // hold the sender until every queued sample has produced its drive;
  // checked at the rising edge, where queue and valid are settled
  task automatic drain();
    do @(posedge clk_i);
    while (sample_q.size() != 0 || in_valid_i || drive_exp_q.size() != 0);
  endtask

  function automatic logic [pidpa_pkg::CFG_DATA_W-1:0] pick_reg(input int unsigned hi);
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return DATA_W'($urandom_range(0, hi));
      default: return DATA_W'($urandom_range(0, DATA_MAX));
    endcase
  endfunction

  task automatic scramble_regs();
    write_reg(pidpa_pkg::CFG_GAIN_P, pick_reg(7));
    write_reg(pidpa_pkg::CFG_GAIN_I, pick_reg(3));
    write_reg(pidpa_pkg::CFG_GAIN_D, pick_reg(7));
    write_reg(pidpa_pkg::CFG_INT_LIMIT, pick_reg(60));
    write_reg(pidpa_pkg::CFG_OUT_LIMIT, pick_reg(600));
    write_reg(pidpa_pkg::CFG_DEAD_BAND, pick_reg(15));
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                DATA_W'($urandom_range(0, DATA_MAX)));
  endtask

  function automatic int clip_pos(input int v);
    if (v < 0) return 0;
    if (v > POS_MAX) return POS_MAX;
    return v;
  endfunction

  // stimulus
  initial begin
    int ph;
    int n;
    int aim;
    int pos;
    int step;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    target_pos_i   = '0;
    measured_pos_i = '0;
    out_ready_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = pidpa_pkg::CFG_GAIN_P;
    cfg_data_i     = '0;
    quiet          = 1'b0;
    in_gap         = 0;
    out_stall      = 0;
    err_cnt        = 0;
    servo_regs = '{gain_p: pidpa_pkg::GAIN_P_RST, gain_i: pidpa_pkg::GAIN_I_RST,
                   gain_d: pidpa_pkg::GAIN_D_RST,
                   integral_limit: pidpa_pkg::INT_LIMIT_RST,
                   output_limit: pidpa_pkg::OUT_LIMIT_RST,
                   dead_band: pidpa_pkg::DBAND_RST};
    integ_acc = '0;
    last_meas = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values: first sample sees a zero previous position, field extremes
    push_sample(300, 700);
    push_sample(0, 0);
    push_sample(POS_MAX, 0);
    push_sample(0, POS_MAX);
    push_sample(POS_MAX, POS_MAX);
    // error at the dead band and just past it
    push_sample(500, 499);
    push_sample(499, 500);
    push_sample(502, 500);
    drain();

    // full gains and limits, wide data on the P gain and dead band writes
    write_reg(pidpa_pkg::CFG_GAIN_P, '1);
    write_reg(pidpa_pkg::CFG_GAIN_I, 11'd255);
    write_reg(pidpa_pkg::CFG_GAIN_D, 11'd255);
    write_reg(pidpa_pkg::CFG_INT_LIMIT, 11'd2047);
    write_reg(pidpa_pkg::CFG_OUT_LIMIT, 11'd2047);
    write_reg(pidpa_pkg::CFG_DEAD_BAND, '1);
    // integral runs into its limit
    push_sample(POS_MAX, 0);
    push_sample(POS_MAX, 0);
    push_sample(POS_MAX, 0);
    push_sample(15, 0);
    push_sample(16, 0);
    push_sample(0, POS_MAX);
    drain();

    // integral limit lowered under the stored sum
    write_reg(pidpa_pkg::CFG_INT_LIMIT, 11'd5);
    write_reg(pidpa_pkg::CFG_GAIN_P, 11'd1);
    write_reg(pidpa_pkg::CFG_GAIN_I, 11'd1);
    write_reg(pidpa_pkg::CFG_GAIN_D, 11'd0);
    write_reg(pidpa_pkg::CFG_OUT_LIMIT, 11'd100);
    write_reg(pidpa_pkg::CFG_DEAD_BAND, 11'd0);
    push_sample(600, 600);
    drain();

    // drive landing exactly on the output limit and one past it
    write_reg(pidpa_pkg::CFG_INT_LIMIT, 11'd0);
    write_reg(pidpa_pkg::CFG_GAIN_I, 11'd255);
    push_sample(200, 100);
    push_sample(201, 100);
    push_sample(100, 200);
    push_sample(99, 200);
    drain();

    // zero output limit, writes to unmapped indexes
    write_reg(pidpa_pkg::CFG_OUT_LIMIT, 11'd0);
    write_reg(CFG_SPARE_A, '1);
    write_reg(CFG_SPARE_B, 11'h123);
    write_reg(pidpa_pkg::CFG_GAIN_D, 11'd1);
    push_sample(5, 5);
    push_sample(5, 5);
    push_sample(6, 5);

    // random phases: mostly a position tracking its setpoint, some noise
    for (ph = 0; ph < 8; ph++) begin
      drain();
      scramble_regs();
      quiet = (ph == 2 || ph == 5);
      aim = $urandom_range(0, POS_MAX);
      pos = $urandom_range(0, POS_MAX);
      for (n = 0; n < 100; n++) begin
        if ($urandom_range(0, 9) < 3) begin
          push_sample($urandom_range(0, POS_MAX), $urandom_range(0, POS_MAX));
        end else begin
          if ($urandom_range(0, 19) == 0) aim = $urandom_range(0, POS_MAX);
          step = int'($urandom_range(0, 24)) - 4;
          pos  = clip_pos((pos <= aim) ? pos + step : pos - step);
          push_sample(clip_pos(aim + int'($urandom_range(0, 6)) - 3), pos);
        end
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
